// ===== hw/rtl/recursive_mutex_fifo_waiters_defines.svh =====
// Assertion macros shared by the recursive mutex RTL.
`ifndef RECURSIVE_MUTEX_FIFO_WAITERS_DEFINES_SVH
`define RECURSIVE_MUTEX_FIFO_WAITERS_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define RMFW_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RMFW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RMFW_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define RMFW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/rmfw_pkg.sv =====
// Types and constants of the recursive mutex with its FIFO of waiting threads.
`timescale 1ns / 1ps
`default_nettype none

package rmfw_pkg;

  localparam int unsigned TID_W    = 8;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned STATUS_W = 4;
  localparam int unsigned NUM_TIDS = 1 << TID_W;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED   = 4'd0,
    ST_REENTERED = 4'd1,
    ST_QUEUED    = 4'd2,
    ST_LOWERED   = 4'd3,
    ST_FREED     = 4'd4,
    ST_HANDOFF   = 4'd5,
    ST_NOT_HOLD  = 4'd6,
    ST_FULL      = 4'd7,
    ST_WAITING   = 4'd8,
    ST_SATURATED = 4'd9
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_e;

  typedef struct packed {
    logic rd_en;
    logic push;
    logic pop;
  } waitq_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic waiting;
  } waitq_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rmfw_if.sv =====
// Request and response channel interfaces of the recursive mutex.
`timescale 1ns / 1ps
`default_nettype none

interface rmfw_req_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [rmfw_pkg::TID_W-1:0] thread_id;

  modport source (output valid, output op, output thread_id, input ready);
  modport sink   (input valid, input op, input thread_id, output ready);
endinterface

interface rmfw_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [rmfw_pkg::STATUS_W-1:0] status;
  logic                          woken_valid;
  logic [rmfw_pkg::TID_W-1:0]    woken_thread;
  logic [rmfw_pkg::CNT_W-1:0]    hold_count;

  modport source (output valid, output status, output woken_valid, output woken_thread,
                  output hold_count, input ready);
  modport sink   (input valid, input status, input woken_valid, input woken_thread,
                  input hold_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rmfw_waitq.sv =====
// Wait queue: FIFO memory of thread ids, its pointers, and per-thread waiting flags.
`timescale 1ns / 1ps
`default_nettype none

module rmfw_waitq #(
  parameter int unsigned WAIT_DEPTH = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire rmfw_pkg::waitq_ctrl_t        ctrl_i,
  input  wire logic [rmfw_pkg::TID_W-1:0]   push_tid_i,
  input  wire logic [rmfw_pkg::TID_W-1:0]   lookup_tid_i,
  output rmfw_pkg::waitq_stat_t             stat_o,
  output logic [rmfw_pkg::TID_W-1:0]        head_tid_o
);
  import rmfw_pkg::*;

  localparam int unsigned PtrW  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int unsigned FillW = $clog2(WAIT_DEPTH + 1);

  logic [TID_W-1:0]    mem_q [WAIT_DEPTH];
  logic [TID_W-1:0]    rd_data_q;
  logic [PtrW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [FillW-1:0]    fill_q, fill_d;
  logic [NUM_TIDS-1:0] flag_q, flag_d;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    ptr_next = (p == PtrW'(WAIT_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  // The memory holds thread ids; the head is read into a register in the cycle before its use.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[tail_q] <= push_tid_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem_q[head_q];
    end
  end

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    fill_d = fill_q;
    flag_d = flag_q;
    if (ctrl_i.push) begin
      tail_d             = ptr_next(tail_q);
      fill_d             = fill_q + FillW'(1);
      flag_d[push_tid_i] = 1'b1;
    end else if (ctrl_i.pop) begin
      head_d            = ptr_next(head_q);
      fill_d            = fill_q - FillW'(1);
      flag_d[rd_data_q] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
      flag_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
      flag_q <= flag_d;
    end
  end

  assign stat_o.empty   = (fill_q == '0);
  assign stat_o.full    = (fill_q == FillW'(WAIT_DEPTH));
  assign stat_o.waiting = flag_q[lookup_tid_i];
  assign head_tid_o     = rd_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/recursive_mutex_fifo_waiters.sv =====
// Top level of the recursive mutex with a FIFO queue of waiting threads.
`timescale 1ns / 1ps
`default_nettype none

`include "recursive_mutex_fifo_waiters_defines.svh"

// Recursive hardware mutex. Each request word carries an acquire or a release from one
// thread id and produces exactly one response word. The owner may re-acquire the lock,
// which raises its hold count up to MAX_HOLD_COUNT. An acquire from any other thread
// while the lock is taken places that thread at the tail of a wait queue of WAIT_DEPTH
// entries; when the owner's final release arrives the lock passes straight to the
// thread at the head of the queue, which is reported in the response as woken. Faults
// (release by a thread that does not hold the lock, a full queue, a thread that is
// already waiting, a saturated hold count) are returned as status codes and leave the
// state untouched. A request first reads the head entry of the wait-queue memory, whose
// read data is registered; the decision step then decides, updates the state and loads
// the response register. A new request is taken only when the previous one has been
// decided and the response register is empty or its word leaves in that cycle, so a
// response held by the receiver stalls the request side until it has gone. There is no
// clearing pass after reset: the queue memory is read at its head on every request, but
// that entry is used only when the queue holds a waiter, and the per-thread waiting
// flags are flip-flops cleared by reset.

module recursive_mutex_fifo_waiters #(
  parameter int unsigned WAIT_DEPTH     = 16,
  parameter int unsigned MAX_HOLD_COUNT = 65535
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  rmfw_req_if.sink  req_i,
  rmfw_rsp_if.source rsp_o
);
  import rmfw_pkg::*;

  fsm_e state_q, state_d;

  // Request registered at acceptance.
  logic             rq_op_q;
  logic [TID_W-1:0] rq_tid_q;

  // Lock state.
  logic             taken_q, taken_d;
  logic [TID_W-1:0] owner_q, owner_d;
  logic [CNT_W-1:0] count_q, count_d;

  // Response register.
  logic             out_valid_q, out_valid_d;
  status_e          out_status_q, status_d;
  logic             out_woken_q, woken_d;
  logic [TID_W-1:0] out_woken_tid_q, woken_tid_d;
  logic [CNT_W-1:0] out_count_q;

  waitq_ctrl_t      wq_ctrl;
  waitq_stat_t      wq_stat;
  logic [TID_W-1:0] head_tid;
  logic             req_accept;
  logic             is_owner;

  // The FSM is idle and the response slot is free, or its word leaves in this cycle.
  assign req_i.ready = (state_q == FSM_IDLE) && (!out_valid_q || rsp_o.ready);
  assign req_accept  = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      rq_op_q  <= req_i.op;
      rq_tid_q <= req_i.thread_id;
    end
  end

  rmfw_waitq #(
    .WAIT_DEPTH (WAIT_DEPTH)
  ) u_waitq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (wq_ctrl),
    .push_tid_i   (rq_tid_q),
    .lookup_tid_i (rq_tid_q),
    .stat_o       (wq_stat),
    .head_tid_o   (head_tid)
  );

  assign is_owner = taken_q && (owner_q == rq_tid_q);

  // Decision step. The queue memory is written only here and read only at
  // acceptance, so a read never meets a write to the same entry in one cycle.
  always_comb begin
    state_d     = state_q;
    taken_d     = taken_q;
    owner_d     = owner_q;
    count_d     = count_q;
    status_d    = ST_NOT_HOLD;
    woken_d     = 1'b0;
    woken_tid_d = '0;
    out_valid_d = out_valid_q;
    wq_ctrl     = '0;

    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      FSM_IDLE: begin
        if (req_accept) begin
          wq_ctrl.rd_en = 1'b1;
          state_d       = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        out_valid_d = 1'b1;
        state_d     = FSM_IDLE;
        if (rq_op_q == OP_ACQUIRE) begin
          if (is_owner) begin
            if (count_q >= CNT_W'(MAX_HOLD_COUNT)) begin
              status_d = ST_SATURATED;
            end else begin
              count_d  = count_q + CNT_W'(1);
              status_d = ST_REENTERED;
            end
          end else if (!taken_q) begin
            taken_d  = 1'b1;
            owner_d  = rq_tid_q;
            count_d  = CNT_W'(1);
            status_d = ST_GRANTED;
          end else if (wq_stat.waiting) begin
            status_d = ST_WAITING;
          end else if (wq_stat.full) begin
            status_d = ST_FULL;
          end else begin
            wq_ctrl.push = 1'b1;
            status_d     = ST_QUEUED;
          end
        end else begin
          if (!is_owner) begin
            status_d = ST_NOT_HOLD;
          end else if (count_q > CNT_W'(1)) begin
            count_d  = count_q - CNT_W'(1);
            status_d = ST_LOWERED;
          end else if (!wq_stat.empty) begin
            // Final release with waiters: the head thread takes the lock at once.
            wq_ctrl.pop = 1'b1;
            owner_d     = head_tid;
            count_d     = CNT_W'(1);
            woken_d     = 1'b1;
            woken_tid_d = head_tid;
            status_d    = ST_HANDOFF;
          end else begin
            taken_d  = 1'b0;
            owner_d  = '0;
            count_d  = '0;
            status_d = ST_FREED;
          end
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      taken_q     <= 1'b0;
      owner_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      taken_q     <= taken_d;
      owner_q     <= owner_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FSM_EXEC) begin
      out_status_q    <= status_d;
      out_woken_q     <= woken_d;
      out_woken_tid_q <= woken_tid_d;
      out_count_q     <= count_d;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.woken_valid  = out_woken_q;
  assign rsp_o.woken_thread = out_woken_tid_q;
  assign rsp_o.hold_count   = out_count_q;

  // A request is only taken when its response has a free slot to land in.
  `RMFW_ASSERT_NOW(a_slot_free, clk_i, rst_ni, state_q == FSM_EXEC, !out_valid_q, "slot busy")
  // A free lock never carries a hold count, and a held one always does.
  `RMFW_ASSERT_NOW(a_count_match, clk_i, rst_ni, 1'b1, taken_q == (count_q != '0), "count/lock")
  // A handoff only ever pops a queue that holds a waiter.
  `RMFW_ASSERT_NOW(a_pop_nonempty, clk_i, rst_ni, wq_ctrl.pop, !wq_stat.empty && taken_q, "pop empty")
  // Every accepted request is decided in the following cycle.
  `RMFW_ASSERT_NEXT(a_exec_follows, clk_i, rst_ni, req_accept, state_q == FSM_EXEC, "not decided")

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench of the recursive mutex with its FIFO queue of waiting threads.
`timescale 1ns / 1ps

// The bench drives request words (acquire or release from one thread id) into the
// mutex and checks every response word against a predictor of its own. That predictor
// keeps the lock flag, the holder, the re-entry count and a queue of waiting threads.
//
// The run has three phases:
//   - A short directed table. It covers release while free, grant, re-entry, queueing,
//     already waiting, release by a non-holder, handoff and free. Rows whose answer is
//     obvious carry a typed-in response. The other rows are checked against the
//     predictor.
//   - About 1100 random words, built from short episodes:
//       fill-and-drain episodes push the wait queue past full, then hand the lock
//         down the queue;
//       pool episodes draw thread ids from a small cluster, so re-entry and
//         already-waiting cases are common;
//       noise episodes use any op with any thread id.
//   - A climb: one thread re-enters to a deep hold count, queues a waiter, then
//     releases all the way down to the handoff.

module testbench;
  import rmfw_pkg::*;

  localparam int unsigned WAIT_DEPTH = 16;
  localparam int unsigned MAX_HOLD   = 65535;
  localparam int unsigned RAND_WORDS = 1100;
  localparam int unsigned DIR_ROWS   = 19;
  // Hold count reached by the closing climb.
  localparam int unsigned CLIMB_DEPTH = 32;
  // Length of the forced receiver stall, long enough for the mutex to back up into
  // its request port.
  localparam int unsigned HOLD_OFF   = 64;
  // The longest correct quiet stretch is the forced stall plus a run of random idles
  // on both sides; this limit is many times that.
  localparam int unsigned QUIET_LIMIT = 1000;

  localparam logic [TID_W-1:0] CLIMB_TID    = 8'h5A;
  localparam logic [TID_W-1:0] CLIMB_WAITER = 8'hA5;

  // One response word as the mutex returns it.
  typedef struct packed {
    status_e          status;
    logic             woken_valid;
    logic [TID_W-1:0] woken_thread;
    logic [CNT_W-1:0] hold_count;
  } mutex_rsp_t;

  // One row of the directed table; known marks a row whose response is typed in.
  typedef struct packed {
    logic       op;
    logic [TID_W-1:0] tid;
    logic       known;
    mutex_rsp_t rsp;
  } dir_row_t;

  logic clk;
  logic rst_n;

  rmfw_req_if req_if ();
  rmfw_rsp_if rsp_if ();

  recursive_mutex_fifo_waiters #(
    .WAIT_DEPTH    (WAIT_DEPTH),
    .MAX_HOLD_COUNT(MAX_HOLD)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Predicted state of the lock.
  logic             lock_held;
  logic [TID_W-1:0] holder;
  logic [CNT_W-1:0] hold_cnt;
  logic [TID_W-1:0] waiters[$];

  // Responses still owed by the mutex, oldest first.
  mutex_rsp_t pending_rsp[$];
  mutex_rsp_t want_rsp;

  dir_row_t    dir_table[DIR_ROWS];
  int unsigned status_seen[10];
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned fails;
  int unsigned quiet;
  int unsigned dir_words;

  // Shared knobs between the stimulus and the response-side ready process.
  bit idling;
  bit hold_off_req;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Predictor: applies one request word to the predicted state and returns the response.
  function automatic mutex_rsp_t mutex_step(input logic op, input logic [TID_W-1:0] tid);
    mutex_rsp_t r;
    bit         in_queue;
    r        = '0;
    in_queue = 1'b0;
    foreach (waiters[i]) begin
      if (waiters[i] == tid) in_queue = 1'b1;
    end
    if (op == OP_ACQUIRE) begin
      if (lock_held && holder == tid) begin
        // The holder comes back: re-entry, unless the count is already at its ceiling.
        if (hold_cnt >= MAX_HOLD) begin
          r.status = ST_SATURATED;
        end else begin
          hold_cnt++;
          r.status = ST_REENTERED;
        end
      end else if (!lock_held) begin
        lock_held = 1'b1;
        holder    = tid;
        hold_cnt  = CNT_W'(1);
        r.status  = ST_GRANTED;
      end else if (in_queue) begin
        // The already-waiting check takes precedence over the full check.
        r.status = ST_WAITING;
      end else if (waiters.size() >= WAIT_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        waiters.push_back(tid);
        r.status = ST_QUEUED;
      end
    end else begin
      if (!lock_held || holder != tid) begin
        r.status = ST_NOT_HOLD;
      end else if (hold_cnt > 1) begin
        hold_cnt--;
        r.status = ST_LOWERED;
      end else if (waiters.size() > 0) begin
        // The final release passes the lock straight to the oldest waiter.
        holder         = waiters.pop_front();
        hold_cnt       = CNT_W'(1);
        r.woken_valid  = 1'b1;
        r.woken_thread = holder;
        r.status       = ST_HANDOFF;
      end else begin
        lock_held = 1'b0;
        holder    = '0;
        hold_cnt  = '0;
        r.status  = ST_FREED;
      end
    end
    r.hold_count = hold_cnt;
    return r;
  endfunction

  function automatic dir_row_t dir_row(input logic op, input logic [TID_W-1:0] tid,
                                       input logic known = 1'b0,
                                       input status_e st = ST_GRANTED,
                                       input logic wv = 1'b0,
                                       input logic [TID_W-1:0] wt = '0,
                                       input logic [CNT_W-1:0] cnt = '0);
    dir_row_t d;
    d.op               = op;
    d.tid              = tid;
    d.known            = known;
    d.rsp.status       = st;
    d.rsp.woken_valid  = wv;
    d.rsp.woken_thread = wt;
    d.rsp.hold_count   = cnt;
    return d;
  endfunction

  // Offers one request word, with a random idle gap first when idling is on, and
  // waits for it to be taken. On acceptance the expected response is queued: the
  // typed-in one where given, otherwise the predictor's.
  task automatic send_word(input logic op, input logic [TID_W-1:0] tid,
                           input logic known = 1'b0, input mutex_rsp_t typed_rsp = '0);
    mutex_rsp_t predicted;
    if (idling && $urandom_range(99) < 38) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
      while (idling && $urandom_range(99) < 38) @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.op        <= op;
    req_if.thread_id <= tid;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    predicted = mutex_step(op, tid);
    pending_rsp.push_back(known ? typed_rsp : predicted);
    words_sent++;
  endtask

  // Sender pause: stop offering words until every outstanding response is back.
  // A clock edge always passes first, so valid is never driven twice in one step.
  task automatic wait_for_responses();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fails++;
    end
  endtask

  // Response side: ready idles at random, except during the forced stall, which is
  // counted here so that the sender keeps offering words meanwhile.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= !(idling && $urandom_range(99) < 38);
      end
      @(posedge clk);
    end
  end

  // Response checker and watchdog. Both channels are sampled just after the rising
  // edge, before any nonblocking update of that step lands.
  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        words_checked++;
        if (pending_rsp.size() == 0) begin
          $error("response word with no request outstanding: status %0d", rsp_if.status);
          fails++;
        end else begin
          want_rsp = pending_rsp.pop_front();
          check_field("status", 32'(want_rsp.status), 32'(rsp_if.status));
          check_field("woken_valid", 32'(want_rsp.woken_valid), 32'(rsp_if.woken_valid));
          check_field("woken_thread", 32'(want_rsp.woken_thread),
                      32'(rsp_if.woken_thread));
          check_field("hold_count", 32'(want_rsp.hold_count), 32'(rsp_if.hold_count));
          status_seen[want_rsp.status]++;
        end
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d responses outstanding",
                 quiet, pending_rsp.size());
        $display("testbench failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned      kind;
    int unsigned      pick;
    int unsigned      n;
    int unsigned      rand_base;
    bit               paused_mid;
    logic             op;
    logic [TID_W-1:0] base;
    logic [TID_W-1:0] tid;

    paused_mid       = 1'b0;
    idling           = 1'b1;
    hold_off_req     = 1'b0;
    words_sent       = 0;
    words_checked    = 0;
    fails            = 0;
    quiet            = 0;
    lock_held        = 1'b0;
    holder           = '0;
    hold_cnt         = '0;
    req_if.valid     <= 1'b0;
    req_if.op        <= OP_ACQUIRE;
    req_if.thread_id <= '0;
    foreach (status_seen[i]) status_seen[i] = 0;

    // Directed table. Thread ids 0, 255, 170 and 85 toggle every id bit both ways.
    dir_table = '{
      // Release while the lock is free, even by the thread id that reset leaves as owner.
      dir_row(OP_RELEASE, 8'd0,   1'b1, ST_NOT_HOLD, 1'b0, 8'd0,   16'd0),
      dir_row(OP_ACQUIRE, 8'd0,   1'b1, ST_GRANTED,  1'b0, 8'd0,   16'd1),
      dir_row(OP_ACQUIRE, 8'd0,   1'b1, ST_REENTERED, 1'b0, 8'd0,  16'd2),
      dir_row(OP_ACQUIRE, 8'd255, 1'b1, ST_QUEUED,   1'b0, 8'd0,   16'd2),
      dir_row(OP_ACQUIRE, 8'd255, 1'b1, ST_WAITING,  1'b0, 8'd0,   16'd2),
      dir_row(OP_RELEASE, 8'd255, 1'b1, ST_NOT_HOLD, 1'b0, 8'd0,   16'd2),
      dir_row(OP_ACQUIRE, 8'd170),
      dir_row(OP_ACQUIRE, 8'd85),
      dir_row(OP_RELEASE, 8'd0,   1'b1, ST_LOWERED,  1'b0, 8'd0,   16'd1),
      dir_row(OP_RELEASE, 8'd0,   1'b1, ST_HANDOFF,  1'b1, 8'd255, 16'd1),
      dir_row(OP_RELEASE, 8'd0,   1'b1, ST_NOT_HOLD, 1'b0, 8'd0,   16'd1),
      dir_row(OP_ACQUIRE, 8'd170),
      dir_row(OP_RELEASE, 8'd255),
      dir_row(OP_RELEASE, 8'd170),
      dir_row(OP_ACQUIRE, 8'd85),
      dir_row(OP_RELEASE, 8'd85),
      dir_row(OP_RELEASE, 8'd85,  1'b1, ST_FREED,    1'b0, 8'd0,   16'd0),
      dir_row(OP_ACQUIRE, 8'd255, 1'b1, ST_GRANTED,  1'b0, 8'd0,   16'd1),
      dir_row(OP_RELEASE, 8'd255, 1'b1, ST_FREED,    1'b0, 8'd0,   16'd0)
    };

    @(posedge clk);
    while (!rst_n) @(posedge clk);

    foreach (dir_table[i]) begin
      send_word(dir_table[i].op, dir_table[i].tid, dir_table[i].known, dir_table[i].rsp);
    end
    dir_words = words_sent;
    wait_for_responses();

    // Random part. It opens with the receiver held off while words keep coming, so the
    // mutex fills its pipeline and stalls the request side.
    hold_off_req = 1'b1;
    rand_base    = words_sent;
    while (words_sent - rand_base < RAND_WORDS) begin
      n = words_sent - rand_base;
      // A long stretch in the middle runs at full rate on both sides.
      idling = (n < 400) || (n >= 600);
      if (!paused_mid && n >= 800) begin
        paused_mid = 1'b1;
        wait_for_responses();
      end
      kind = $urandom_range(9);
      if (kind < 2) begin
        // Fill the wait queue past its depth, then hand the lock down the queue.
        if (!lock_held) begin
          tid = TID_W'($urandom_range(255));
          send_word(OP_ACQUIRE, tid);
        end
        repeat (WAIT_DEPTH + 3) begin
          tid = TID_W'($urandom_range(255));
          send_word(OP_ACQUIRE, tid);
        end
        while (lock_held) begin
          if ($urandom_range(9) == 0) begin
            tid = TID_W'($urandom_range(255));
            send_word(OP_RELEASE, tid);
          end
          send_word(OP_RELEASE, holder);
        end
      end else if (kind < 8) begin
        // A small cluster of threads contending for the lock.
        base = TID_W'($urandom_range(255));
        repeat (16) begin
          pick = $urandom_range(99);
          tid  = base + TID_W'($urandom_range(5));
          if (pick < 45) begin
            send_word(OP_ACQUIRE, tid);
          end else if (pick < 80 && lock_held) begin
            send_word(OP_RELEASE, holder);
          end else begin
            send_word(OP_RELEASE, tid);
          end
        end
      end else begin
        repeat (8) begin
          op  = 1'($urandom_range(1));
          tid = TID_W'($urandom_range(255));
          send_word(op, tid);
        end
      end
    end

    // Climb: free the lock, re-enter to a deep count, queue a waiter and come back down.
    idling = 1'b0;
    while (lock_held) send_word(OP_RELEASE, holder);
    send_word(OP_ACQUIRE, CLIMB_TID);
    repeat (CLIMB_DEPTH - 1) send_word(OP_ACQUIRE, CLIMB_TID);
    send_word(OP_ACQUIRE, CLIMB_WAITER);
    repeat (CLIMB_DEPTH - 1) send_word(OP_RELEASE, CLIMB_TID);
    send_word(OP_RELEASE, CLIMB_TID);
    send_word(OP_RELEASE, CLIMB_WAITER);

    wait_for_responses();
    repeat (10) @(posedge clk);
    if (pending_rsp.size() != 0) begin
      $error("%0d responses never arrived", pending_rsp.size());
      fails++;
    end

    $display("Run covered %0d request words (%0d directed), %0d responses checked, %0d faults.",
             words_sent, dir_words, words_checked, fails);
    $display("Statuses: grant %0d reenter %0d queue %0d lower %0d free %0d handoff %0d %s",
             status_seen[ST_GRANTED], status_seen[ST_REENTERED], status_seen[ST_QUEUED],
             status_seen[ST_LOWERED], status_seen[ST_FREED], status_seen[ST_HANDOFF],
             $sformatf("nothold %0d full %0d waiting %0d saturated %0d",
                       status_seen[ST_NOT_HOLD], status_seen[ST_FULL],
                       status_seen[ST_WAITING], status_seen[ST_SATURATED]));
    if (fails == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
